>>> hdl/b64d_pkg.sv
// Shared types, codes and the character classifier for the base64 decoder.
// Used by b64d_front, b64d_queue, b64d_back and base64_decoder_core.
package b64d_pkg;

	localparam logic [7:0] PadChar = 8'h3D;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CHAR = 2'd1,
		ST_BAD_LEN  = 2'd2
	} b64d_status_t;

	typedef enum logic [1:0] {
		CLS_BLANK,
		CLS_PAD,
		CLS_VALUE,
		CLS_BAD
	} b64d_class_t;

	typedef struct packed {
		b64d_class_t cls;
		logic [5:0]  sextet;
	} b64d_char_t;

	// One decoded group as handed from the front to the back. A job with no
	// bytes exists only to carry the end-of-text status.
	typedef struct packed {
		logic [23:0]  value;
		logic [1:0]   nbytes;
		logic         last;
		b64d_status_t status;
	} b64d_job_t;

	function automatic b64d_char_t classify(input logic [7:0] c);
		b64d_char_t r;
		r.cls    = CLS_BAD;
		r.sextet = 6'd0;
		case (c) inside
			[8'h41:8'h5A]: begin
				r.cls    = CLS_VALUE;
				r.sextet = 6'(c - 8'h41);
			end
			[8'h61:8'h7A]: begin
				r.cls    = CLS_VALUE;
				r.sextet = 6'(c - 8'h61 + 8'd26);
			end
			[8'h30:8'h39]: begin
				r.cls    = CLS_VALUE;
				r.sextet = 6'(c - 8'h30 + 8'd52);
			end
			8'h2B: begin
				r.cls    = CLS_VALUE;
				r.sextet = 6'd62;
			end
			8'h2F: begin
				r.cls    = CLS_VALUE;
				r.sextet = 6'd63;
			end
			PadChar: begin
				r.cls = CLS_PAD;
			end
			[8'h09:8'h0D], 8'h20: begin
				r.cls = CLS_BLANK;
			end
			default: begin
				r.cls = CLS_BAD;
			end
		endcase
		return r;
	endfunction

endpackage

>>> hdl/base64_decoder_core.sv
// Top level of the streaming base64 decoder (standard alphabet).
// Instantiates b64d_front, b64d_queue and b64d_back; depends on b64d_pkg.
//
// Usage: characters arrive on the input channel (in_valid/in_ready, fields
// char_in and text_end), one per transfer; text_end marks the last character
// of a text. Decoded bytes leave on the output channel (out_valid/out_ready,
// fields byte_out, byte_valid, run_last, status), one result per transfer.
// The last result of each text has run_last set and carries the status:
// ok, invalid character or invalid length. When a text ends without a
// pending byte, a result with byte_valid low carries that status alone.
//
// Throughput: one character per cycle while the queue has room. The front
// classifies a character and closes a group in the cycle it is accepted; a
// completed group becomes a job in the queue, and the back end drains up to
// three bytes of it, one per cycle while the receiver takes them. The first
// byte of a group is written with its job into the queue and then loaded
// into the output register, from which it can be transferred. Since four
// characters yield at most three bytes, the back end keeps up on average.
//
// When the receiver stalls, the output register holds its result and the
// queue absorbs up to QUEUE_DEPTH jobs; in_ready drops only when it is full.
// Reset (arst_n low) empties the queue, drops any pending result and clears
// the group state, so the next character starts a new text.
module base64_decoder_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       text_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_out,
	output logic       byte_valid,
	output logic       run_last,
	output logic [1:0] status
);
	import b64d_pkg::*;

	logic      accept;
	logic      push;
	logic      pop;
	logic      full;
	logic      empty;
	b64d_job_t front_job;
	b64d_job_t head_job;

	// Any accepted character may produce a job, so the front takes a
	// character only while the queue has room.
	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.char_in  (char_in),
		.text_end (text_end),
		.push     (push),
		.job      (front_job)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (front_job),
		.pop      (pop),
		.head     (head_job),
		.full     (full),
		.empty    (empty)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_job),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.byte_out   (byte_out),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.status     (status)
	);

endmodule

>>> hdl/b64d_front.sv
// Front end of the base64 decoder: accepts characters, classifies them and
// assembles groups of four into jobs for the queue. Depends on b64d_pkg.
module b64d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          char_in,
	input  logic                text_end,
	output logic                push,
	output b64d_pkg::b64d_job_t job
);
	import b64d_pkg::*;

	logic [23:0] acc_q;
	logic [1:0]  pos_q;
	logic [2:0]  vcnt_q;
	logic        bad_q;

	b64d_char_t  ch;
	logic [23:0] acc_n;
	logic [1:0]  pos_n;
	logic [2:0]  vcnt_n;
	logic        bad_n;
	logic        group_done;
	logic [1:0]  nbytes;
	logic [23:0] aligned;

	always_comb begin
		ch         = classify(char_in);
		acc_n      = acc_q;
		vcnt_n     = vcnt_q;
		bad_n      = bad_q;
		pos_n      = pos_q;
		group_done = 1'b0;
		if (ch.cls != CLS_BLANK) begin
			if (ch.cls == CLS_VALUE) begin
				acc_n  = {acc_q[17:0], ch.sextet};
				vcnt_n = vcnt_q + 3'd1;
			end
			if (ch.cls == CLS_BAD) begin
				bad_n = 1'b1;
			end
			pos_n      = pos_q + 2'd1;
			group_done = (pos_q == 2'd3);
		end

		// Left-align the values of a complete group in 24 bits.
		case (vcnt_n)
			3'd3:    aligned = {acc_n[17:0], 6'd0};
			3'd2:    aligned = {acc_n[11:0], 12'd0};
			default: aligned = acc_n;
		endcase

		nbytes = 2'd0;
		if (group_done && !bad_n && vcnt_n >= 3'd2) begin
			nbytes = 2'(vcnt_n - 3'd1);
		end

		job.value  = aligned;
		job.nbytes = nbytes;
		job.last   = text_end;
		if (pos_n != 2'd0) begin
			job.status = ST_BAD_LEN;
		end else if (bad_n) begin
			job.status = ST_BAD_CHAR;
		end else begin
			job.status = ST_OK;
		end

		push = accept && ((nbytes != 2'd0) || text_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pos_q  <= '0;
			vcnt_q <= '0;
			bad_q  <= 1'b0;
		end else if (accept) begin
			if (text_end) begin
				acc_q  <= '0;
				pos_q  <= '0;
				vcnt_q <= '0;
				bad_q  <= 1'b0;
			end else begin
				pos_q <= pos_n;
				bad_q <= bad_n;
				if (group_done) begin
					acc_q  <= '0;
					vcnt_q <= '0;
				end else begin
					acc_q  <= acc_n;
					vcnt_q <= vcnt_n;
				end
			end
		end
	end

	// The text end returns the group state to its reset value.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && text_end |=> pos_q == 2'd0 && bad_q == 1'b0 && vcnt_q == 3'd0)
		else $error("group state not cleared after text end");

	// A group never holds more values than slots filled.
	a_vcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= 3'({1'b0, pos_q}))
		else $error("value count exceeds group position");

	// No bytes leave once a bad character was seen in this text.
	a_no_bytes_after_bad: assert property (@(posedge clk) disable iff (!arst_n)
		bad_q |-> job.nbytes == 2'd0)
		else $error("bytes produced after bad character");

endmodule

>>> hdl/b64d_queue.sv
// Small job queue between the decoder front and back ends.
// Depends on b64d_pkg for the job type.
module b64d_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64d_pkg::b64d_job_t push_job,
	input  logic                pop,
	output b64d_pkg::b64d_job_t head,
	output logic                full,
	output logic                empty
);
	import b64d_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	b64d_job_t       mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign full  = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop && !empty) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/b64d_back.sv
// Back end of the base64 decoder: walks the bytes of each queued job into
// the output register. Depends on b64d_pkg.
module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b64d_pkg::b64d_job_t head,
	input  logic                empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          byte_out,
	output logic                byte_valid,
	output logic                run_last,
	output logic [1:0]          status
);
	import b64d_pkg::*;

	logic [1:0]   idx_q;
	logic         out_valid_q;
	logic [7:0]   byte_q;
	logic         bvalid_q;
	logic         last_q;
	b64d_status_t status_q;

	logic         load;
	logic         final_byte;
	logic [7:0]   sel_byte;

	always_comb begin
		load       = !empty && (!out_valid_q || out_ready);
		final_byte = (head.nbytes == 2'd0) || (idx_q == head.nbytes - 2'd1);
		pop        = load && final_byte;
		case (idx_q)
			2'd0:    sel_byte = head.value[23:16];
			2'd1:    sel_byte = head.value[15:8];
			default: sel_byte = head.value[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_byte ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bvalid_q <= (head.nbytes != 2'd0);
			byte_q   <= (head.nbytes != 2'd0) ? sel_byte : 8'd0;
			last_q   <= head.last && final_byte;
			status_q <= (head.last && final_byte) ? head.status : ST_OK;
		end
	end

	assign out_valid  = out_valid_q;
	assign byte_out   = byte_q;
	assign byte_valid = bvalid_q;
	assign run_last   = last_q;
	assign status     = status_q;

	// A result without a byte exists only as the final status of a text.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !bvalid_q |-> last_q)
		else $error("byteless result not marked last");

	// A nonzero status appears only on the final result.
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> last_q)
		else $error("status on non-final result");

	// Finishing a job restarts the byte index.
	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 2'd0)
		else $error("byte index not restarted after job");

endmodule
